// File: src/magnitude_to_decibels_macros.svh
// ----------------------------------------------------------------------------
// magnitude_to_decibels_macros
// assertion shorthands for the decibel converter checkers
// ----------------------------------------------------------------------------
`ifndef MAGNITUDE_TO_DECIBELS_MACROS_SVH
`define MAGNITUDE_TO_DECIBELS_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define M2DB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define M2DB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/m2db_pkg.sv
// ----------------------------------------------------------------------------
// m2db_pkg
// constants, log table and helpers for the magnitude to decibel converter
// ----------------------------------------------------------------------------
package m2db_pkg;

  // table and output format
  localparam int TableEntries = 128;
  localparam int OutFracBits  = 12;
  localparam int OutW         = 23;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int TblW         = 30;

  // input classification thresholds
  localparam logic [31:0] FloorBits   = 32'h006C_E3EE;
  localparam logic [31:0] CeilBits    = 32'h7E96_7699;
  localparam logic [30:0] NanFloor    = 31'h7F80_0000;
  localparam logic [23:0] SqrtHalfQ24 = 24'hB5_04F3;

  // fixed point constants
  localparam int          Ln2Q30     = 744261118;
  localparam int          Ln2HalfQ30 = Ln2Q30 / 2;
  localparam logic [30:0] DbPowerQ28 = 31'd1165800319;

  // table position scale, Q16 per Q24 step
  localparam logic [63:0] OdxQ = (64'(TableEntries - 1) << 40) / 64'(SqrtHalfQ24);
  localparam int OdxW    = $clog2(OdxQ + 64'd1);
  localparam int IdxRawW = OdxW - 16;

  // datapath widths
  localparam int FracW     = 17;
  localparam int StepProdW = TblW + FracW;
  localparam int EW        = 39;
  localparam int LW        = 40;
  localparam int Mag24W    = 32;
  localparam int ProdW     = Mag24W + 31;

  // final rounding shifts
  localparam int ShPower = 52 - OutFracBits;
  localparam int ShAmp   = ShPower - 1;

  // clip levels
  localparam logic [OutW-1:0] ClipPowerQ    = OutW'(380 << OutFracBits);
  localparam logic [OutW-1:0] ClipAmpQ      = OutW'(760 << OutFracBits);
  localparam logic [OutW-1:0] ClipPowerNegQ = OutW'(-(380 << OutFracBits));
  localparam logic [OutW-1:0] ClipAmpNegQ   = OutW'(-(760 << OutFracBits));
  localparam logic [63:0]     OutMax        = 64'((64'd1 << (OutW - 1)) - 64'd1);

  typedef logic [TblW-1:0] ln_table_t [TableEntries];

  // bitwise restoring divide, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1 + k/(N-1)) in Q30 via the atanh series, truncated products
  function automatic ln_table_t build_ln_table();
    ln_table_t   tbl;
    logic [63:0] b;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    b = 64'(TableEntries - 1);
    for (int k = 0; k < TableEntries; k++) begin
      z    = udiv64(64'(k) << 30, (b << 1) + 64'(k));
      z2   = (z * z) >> 30;
      term = z;
      sum  = '0;
      for (int n = 0; n < 31; n++) begin
        sum  = sum + udiv64(term, 64'(2 * n + 1));
        term = (term * z2) >> 30;
      end
      tbl[k] = TblW'(sum << 1);
    end
    return tbl;
  endfunction

  localparam ln_table_t LnTable = build_ln_table();

endpackage

// File: src/magnitude_to_decibels.sv
// ----------------------------------------------------------------------------
// magnitude_to_decibels
// single precision magnitude to decibel level, power or amplitude scale
// a result shows on done_o once its start transaction has passed every stage register
// throughput: one transaction per cycle, busy_o stays low, no stall exists
// the path holds eight register stages, three of them multiplier stages
// reset clears the stage valid bits and the mode register (power scale)
// ----------------------------------------------------------------------------
module magnitude_to_decibels (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [31:0]                        magnitude_bits_i,
  output logic                               done_o,
  output logic signed [m2db_pkg::OutW-1:0]   level_db_o,
  output logic                               clipped_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_wdata_i
);

  typedef struct packed {
    logic              mode;
    logic              clip;
    logic              clip_hi;
    logic [23:0]       d;
    logic signed [7:0] e;
  } s1_t;

  typedef struct packed {
    logic                             mode;
    logic                             clip;
    logic                             clip_hi;
    logic [m2db_pkg::OdxW-1:0]        y;
    logic signed [m2db_pkg::EW-1:0]   eln;
  } s2_t;

  typedef struct packed {
    logic                             mode;
    logic                             clip;
    logic                             clip_hi;
    logic [m2db_pkg::TblW-1:0]        t0;
    logic [m2db_pkg::TblW-1:0]        step;
    logic [m2db_pkg::FracW-1:0]       f;
    logic signed [m2db_pkg::EW-1:0]   eln;
  } s3_t;

  typedef struct packed {
    logic                             mode;
    logic                             clip;
    logic                             clip_hi;
    logic [m2db_pkg::StepProdW-1:0]   p;
    logic [m2db_pkg::TblW-1:0]        t0;
    logic signed [m2db_pkg::EW-1:0]   eln;
  } s4_t;

  typedef struct packed {
    logic                             mode;
    logic                             clip;
    logic                             clip_hi;
    logic signed [m2db_pkg::LW-1:0]   ln;
  } s5_t;

  typedef struct packed {
    logic                          mode;
    logic                          clip;
    logic                          clip_hi;
    logic                          neg;
    logic [m2db_pkg::Mag24W-1:0]   mag24;
  } s6_t;

  typedef struct packed {
    logic                         mode;
    logic                         clip;
    logic                         clip_hi;
    logic                         neg;
    logic [m2db_pkg::ProdW-1:0]   prod;
  } s7_t;

  localparam logic signed [m2db_pkg::EW-1:0] Ln2S     = m2db_pkg::EW'(m2db_pkg::Ln2Q30);
  localparam logic signed [m2db_pkg::EW-1:0] Ln2HalfS = m2db_pkg::EW'(m2db_pkg::Ln2HalfQ30);

  logic        accept;
  logic        mode_q;
  logic [6:0]  vld_q;
  logic [6:0]  vld_d;
  s1_t         s1_d, s1_q;
  s2_t         s2_d, s2_q;
  s3_t         s3_d, s3_q;
  s4_t         s4_d, s4_q;
  s5_t         s5_d, s5_q;
  s6_t         s6_d, s6_q;
  s7_t         s7_d, s7_q;
  logic                               done_q;
  logic [m2db_pkg::OutW-1:0]          level_d, level_q;
  logic                               clipped_d, clipped_q;

  // handshake: the pipeline never stalls
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // mode register, written by a configuration transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // stage 1: classify, unpack, renormalize mantissa
  always_comb begin
    logic [7:0]        biased;
    logic              floor_hit;
    logic              ceil_hit;
    logic [23:0]       sig;
    logic signed [9:0] e_raw;
    logic signed [9:0] e_adj;
    logic [24:0]       mq;
    logic [24:0]       diff;
    biased    = magnitude_bits_i[30:23];
    floor_hit = magnitude_bits_i[31] || (magnitude_bits_i[30:0] > m2db_pkg::NanFloor)
                || (magnitude_bits_i < m2db_pkg::FloorBits);
    ceil_hit  = magnitude_bits_i > m2db_pkg::CeilBits;
    // in-range subnormals all have bit 22 set, one shift normalizes them
    if (biased != 8'd0) begin
      sig   = {1'b1, magnitude_bits_i[22:0]};
      e_raw = $signed({2'b00, biased}) - 10'sd126;
    end else begin
      sig   = {magnitude_bits_i[22:0], 1'b0};
      e_raw = -10'sd126;
    end
    if (sig < m2db_pkg::SqrtHalfQ24) begin
      mq    = {sig, 1'b0};
      e_adj = e_raw - 10'sd1;
    end else begin
      mq    = {1'b0, sig};
      e_adj = e_raw;
    end
    diff         = mq - {1'b0, m2db_pkg::SqrtHalfQ24};
    s1_d.mode    = mode_q;
    s1_d.clip    = floor_hit || ceil_hit;
    s1_d.clip_hi = !floor_hit;
    s1_d.d       = diff[23:0];
    s1_d.e       = e_adj[7:0];
  end

  // stage 2: table position and exponent term
  always_comb begin
    logic [24+m2db_pkg::OdxW-1:0] ymul;
    ymul         = s1_q.d * m2db_pkg::OdxQ[m2db_pkg::OdxW-1:0];
    s2_d.mode    = s1_q.mode;
    s2_d.clip    = s1_q.clip;
    s2_d.clip_hi = s1_q.clip_hi;
    s2_d.y       = ymul[24 +: m2db_pkg::OdxW];
    s2_d.eln     = m2db_pkg::EW'($signed(s1_q.e)) * Ln2S - Ln2HalfS;
  end

  // stage 3: clamp index, read the two table neighbors
  always_comb begin
    logic [m2db_pkg::IdxRawW-1:0] idx_raw;
    logic [m2db_pkg::IdxW-1:0]    idx;
    logic [m2db_pkg::TblW-1:0]    t0;
    logic [m2db_pkg::TblW-1:0]    t1;
    idx_raw = s2_q.y[m2db_pkg::OdxW-1:16];
    if (idx_raw > m2db_pkg::IdxRawW'(m2db_pkg::TableEntries - 2)) begin
      idx    = m2db_pkg::IdxW'(m2db_pkg::TableEntries - 2);
      s3_d.f = m2db_pkg::FracW'(32'h1_0000);
    end else begin
      idx    = idx_raw[m2db_pkg::IdxW-1:0];
      s3_d.f = {1'b0, s2_q.y[15:0]};
    end
    t0           = m2db_pkg::LnTable[idx];
    t1           = m2db_pkg::LnTable[idx + m2db_pkg::IdxW'(1)];
    s3_d.mode    = s2_q.mode;
    s3_d.clip    = s2_q.clip;
    s3_d.clip_hi = s2_q.clip_hi;
    s3_d.t0      = t0;
    s3_d.step    = (t1 >= t0) ? t1 - t0 : '0;
    s3_d.eln     = s2_q.eln;
  end

  // stage 4: interpolation product
  always_comb begin
    s4_d.mode    = s3_q.mode;
    s4_d.clip    = s3_q.clip;
    s4_d.clip_hi = s3_q.clip_hi;
    s4_d.p       = s3_q.step * s3_q.f;
    s4_d.t0      = s3_q.t0;
    s4_d.eln     = s3_q.eln;
  end

  // stage 5: natural log in Q30
  always_comb begin
    s5_d.mode    = s4_q.mode;
    s5_d.clip    = s4_q.clip;
    s5_d.clip_hi = s4_q.clip_hi;
    s5_d.ln      = $signed(m2db_pkg::LW'(s4_q.t0))
                   + $signed(m2db_pkg::LW'(s4_q.p[m2db_pkg::StepProdW-1:16]))
                   + m2db_pkg::LW'(s4_q.eln);
  end

  // stage 6: magnitude, rounded to Q24
  always_comb begin
    logic [m2db_pkg::LW-1:0] mag;
    logic                    neg;
    neg          = s5_q.ln[m2db_pkg::LW-1];
    mag          = neg ? m2db_pkg::LW'(0) - s5_q.ln : s5_q.ln;
    s6_d.mode    = s5_q.mode;
    s6_d.clip    = s5_q.clip;
    s6_d.clip_hi = s5_q.clip_hi;
    s6_d.neg     = neg;
    s6_d.mag24   = m2db_pkg::Mag24W'((mag + m2db_pkg::LW'(32)) >> 6);
  end

  // stage 7: scale to decibels
  always_comb begin
    s7_d.mode    = s6_q.mode;
    s7_d.clip    = s6_q.clip;
    s7_d.clip_hi = s6_q.clip_hi;
    s7_d.neg     = s6_q.neg;
    s7_d.prod    = s6_q.mag24 * m2db_pkg::DbPowerQ28;
  end

  // output stage: round, apply sign, saturate, select clip level
  always_comb begin
    logic [63:0] sum_pw;
    logic [63:0] sum_amp;
    logic [63:0] r;
    sum_pw  = 64'(s7_q.prod) + (64'd1 << (m2db_pkg::ShPower - 1));
    sum_amp = 64'(s7_q.prod) + (64'd1 << (m2db_pkg::ShAmp - 1));
    r       = s7_q.mode ? (sum_amp >> m2db_pkg::ShAmp) : (sum_pw >> m2db_pkg::ShPower);
    if (s7_q.clip) begin
      if (s7_q.clip_hi) begin
        level_d = s7_q.mode ? m2db_pkg::ClipAmpQ : m2db_pkg::ClipPowerQ;
      end else begin
        level_d = s7_q.mode ? m2db_pkg::ClipAmpNegQ : m2db_pkg::ClipPowerNegQ;
      end
    end else if (s7_q.neg) begin
      if (r > m2db_pkg::OutMax + 64'd1) begin
        level_d = {1'b1, {(m2db_pkg::OutW - 1){1'b0}}};
      end else begin
        level_d = m2db_pkg::OutW'(64'd0 - r);
      end
    end else begin
      if (r > m2db_pkg::OutMax) begin
        level_d = m2db_pkg::OutW'(m2db_pkg::OutMax);
      end else begin
        level_d = m2db_pkg::OutW'(r);
      end
    end
    clipped_d = s7_q.clip;
  end

  // valid bits travel with the stages
  assign vld_d = {vld_q[5:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[6];
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    s3_q      <= s3_d;
    s4_q      <= s4_d;
    s5_q      <= s5_d;
    s6_q      <= s6_d;
    s7_q      <= s7_d;
    level_q   <= level_d;
    clipped_q <= clipped_d;
  end

  assign done_o     = done_q;
  assign level_db_o = $signed(level_q);
  assign clipped_o  = clipped_q;

endmodule

// File: src/m2db_checker.sv
// ----------------------------------------------------------------------------
// m2db_checker
// port-level timing and clip value checks for the decibel converter
// ----------------------------------------------------------------------------
`include "magnitude_to_decibels_macros.svh"

module m2db_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              done_o,
  input logic signed [m2db_pkg::OutW-1:0]  level_db_o,
  input logic                              clipped_o
);

  logic clip_level_ok;

  // the four levels a clipped result may carry
  assign clip_level_ok = (level_db_o == m2db_pkg::ClipPowerQ)
                         || (level_db_o == m2db_pkg::ClipAmpQ)
                         || (level_db_o == m2db_pkg::ClipPowerNegQ)
                         || (level_db_o == m2db_pkg::ClipAmpNegQ);

  // every start transaction is followed by its result on done_o
  `M2DB_ASSERT_NEXT(a_fixed_latency, start_i && !busy_o, ##7 done_o, "no result after start")

  // no result without a matching start transaction
  `M2DB_ASSERT_IMPL(a_no_phantom, done_o, $past(start_i && !busy_o, 8), "result without start")

  // a clipped result carries one of the four clip levels
  `M2DB_ASSERT_IMPL(a_clip_level, done_o && clipped_o, clip_level_ok, "clip level off")

endmodule

bind magnitude_to_decibels m2db_checker u_m2db_checker (.*);

// File: tb/sv/db_level_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// db_level_checker
// watches the start, result and mode write channels of the decibel converter,
// works out the level of every accepted magnitude and compares it, in order,
// with the results that come out of the block
// ----------------------------------------------------------------------------
module db_level_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [31:0]                      magnitude_bits_i,
  input  logic                             done_i,
  input  logic signed [m2db_pkg::OutW-1:0] level_db_i,
  input  logic                             clipped_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic                             cfg_wdata_i,
  output int                               mismatches_o,
  output int                               outstanding_o
);

  localparam int LevelW     = m2db_pkg::OutW;
  localparam int RomDepth   = 128;
  localparam int FracOut    = 12;
  localparam int ReportMax  = 10;

  localparam logic [31:0] LowClipBits  = 32'h006C_E3EE;
  localparam logic [31:0] HighClipBits = 32'h7E96_7699;
  localparam logic [30:0] InfBits      = 31'h7F80_0000;
  localparam logic [23:0] HalfRootQ24  = 24'hB5_04F3;

  localparam longint          Ln2Q30      = 744261118;
  localparam longint unsigned DbScaleQ28  = 64'd1165800319;
  localparam longint unsigned StepScale   =
    (64'(RomDepth - 1) << 40) / 64'(HalfRootQ24);

  typedef struct packed {
    logic [31:0]              magnitude;
    logic signed [LevelW-1:0] level;
    logic                     clipped;
  } db_result_t;

  // ln(1 + k/(N-1)) in Q30, built from the atanh series with truncated terms
  longint unsigned ln_rom [RomDepth];

  initial begin
    longint unsigned span;
    longint unsigned z;
    longint unsigned z_sq;
    longint unsigned term;
    longint unsigned acc;
    span = 64'(RomDepth - 1);
    for (int k = 0; k < RomDepth; k++) begin
      z    = (64'(k) << 30) / (2 * span + 64'(k));
      z_sq = (z * z) >> 30;
      term = z;
      acc  = 0;
      for (int n = 0; n < 31; n++) begin
        acc  = acc + term / 64'(2 * n + 1);
        term = (term * z_sq) >> 30;
      end
      ln_rom[k] = (2 * acc) & 64'hFFFF_FFFF;
    end
  end

  // level and clip flag that one magnitude should give
  function automatic db_result_t predict_db(input logic [31:0] bits, input logic amp);
    db_result_t      res;
    longint          limit;
    logic [23:0]     sig;
    int              expo;
    longint unsigned mant;
    longint unsigned delta;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned slope;
    longint unsigned tbl_ln;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned rounded;
    longint          ln30;
    longint          level;
    longint          sat_hi;
    int              shamt;
    logic            neg;
    res.magnitude = bits;
    res.clipped   = 1'b1;
    limit         = longint'(amp ? 760 : 380) << FracOut;
    sat_hi        = (longint'(1) << (LevelW - 1)) - 1;
    // negatives, nan and tiny values take the floor
    if (bits[31] || bits[30:0] > InfBits || bits < LowClipBits) begin
      res.level = LevelW'(-limit);
    end else if (bits > HighClipBits) begin
      res.level = LevelW'(limit);
    end else begin
      res.clipped = 1'b0;
      sig         = {1'b0, bits[22:0]};
      if (bits[30:23] != 8'd0) begin
        sig[23] = 1'b1;
        expo    = int'(bits[30:23]) - 126;
      end else begin
        // subnormal: shift the significand up to a leading one
        expo = -125;
        while (sig != 24'd0 && !sig[23]) begin
          sig  = sig << 1;
          expo = expo - 1;
        end
      end
      // bring the mantissa into sqrt(0.5) .. sqrt(2)
      mant = 64'(sig);
      if (sig < HalfRootQ24) begin
        mant = 64'(sig) << 1;
        expo = expo - 1;
      end
      delta = (mant >= 64'(HalfRootQ24)) ? mant - 64'(HalfRootQ24) : 64'd0;
      // table lookup with linear interpolation, clamped at the last entry
      pos  = (delta * StepScale) >> 24;
      idx  = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx > 64'(RomDepth - 2)) begin
        idx  = 64'(RomDepth - 2);
        frac = 64'h1_0000;
      end
      slope  = (ln_rom[idx + 1] >= ln_rom[idx]) ? ln_rom[idx + 1] - ln_rom[idx] : 64'd0;
      tbl_ln = ln_rom[idx] + ((slope * frac) >> 16);
      ln30   = longint'(tbl_ln) + longint'(expo) * Ln2Q30 - Ln2Q30 / 2;
      // scale the magnitude and round half up, then restore the sign
      neg     = ln30 < 0;
      mag     = neg ? longint'(-ln30) : longint'(ln30);
      mag     = (mag + 64'd32) >> 6;
      prod    = mag * DbScaleQ28;
      shamt   = 52 - FracOut - int'(amp);
      rounded = (prod + (64'd1 << (shamt - 1))) >> shamt;
      level   = neg ? -longint'(rounded) : longint'(rounded);
      if (level > sat_hi) level = sat_hi;
      if (level < -sat_hi - 1) level = -sat_hi - 1;
      res.level = LevelW'(level);
    end
    return res;
  endfunction

  db_result_t expected_db_q [$];
  logic       amp_mode;
  int         mismatch_total;

  // compare each result with the oldest prediction, then record new transactions
  always @(posedge clk_i or negedge rst_ni) begin
    db_result_t want;
    if (!rst_ni) begin
      expected_db_q.delete();
      amp_mode       <= 1'b0;
      mismatch_total = 0;
      mismatches_o   <= 0;
      outstanding_o  <= 0;
    end else begin
      if (done_i) begin
        if (expected_db_q.size() == 0) begin
          if (mismatch_total < ReportMax)
            $display("unexpected result: level %0d clipped %b", level_db_i, clipped_i);
          mismatch_total = mismatch_total + 1;
        end else begin
          want = expected_db_q.pop_front();
          if (want.level !== level_db_i || want.clipped !== clipped_i) begin
            if (mismatch_total < ReportMax)
              $display("mismatch on %h: expected level %0d clipped %b, got level %0d clipped %b",
                       want.magnitude, $signed(want.level), want.clipped,
                       level_db_i, clipped_i);
            mismatch_total = mismatch_total + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_db_q.push_back(predict_db(magnitude_bits_i, amp_mode));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        amp_mode <= cfg_wdata_i;
      end
      mismatches_o  <= mismatch_total;
      outstanding_o <= expected_db_q.size();
    end
  end

endmodule

// File: tb/sv/tb_magnitude_to_decibels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_magnitude_to_decibels
// drives corner magnitudes and then random magnitudes in both scale modes,
// with and without sender gaps, and gives the verdict from the checker's count
// ----------------------------------------------------------------------------
module tb_magnitude_to_decibels;

  localparam int ItemsPerPhase = 362;
  localparam int SettleCycles  = 12;
  localparam int QuietLimit    = 1000;
  localparam int PhaseCount    = 4;

  localparam int   PhaseIdlePct [PhaseCount] = '{0, 88, 0, 9};
  localparam logic PhaseAmp     [PhaseCount] = '{1'b1, 1'b0, 1'b1, 1'b0};

  localparam int CornerCount = 22;
  localparam logic [31:0] CornerMagnitudes [CornerCount] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'hBF80_0000,
    32'h0000_0001, 32'h006C_E3ED, 32'h006C_E3EE, 32'h0040_0000,
    32'h007F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'h3F35_04F3,
    32'h3F35_04F2, 32'h3FB5_04F2, 32'h3F7F_FFFF, 32'h7E96_7699,
    32'h7E96_769A, 32'h7F7F_FFFF
  };

  logic                             clk_i            = 1'b0;
  logic                             rst_ni           = 1'b0;
  logic                             start_i          = 1'b0;
  logic [31:0]                      magnitude_bits_i = '0;
  logic                             cfg_valid_i      = 1'b0;
  logic                             cfg_wdata_i      = 1'b0;
  logic                             busy_o;
  logic                             done_o;
  logic signed [m2db_pkg::OutW-1:0] level_db_o;
  logic                             clipped_o;
  logic                             cfg_ready_o;

  int mismatches;
  int outstanding;
  int idle_pct;
  int quiet_cycles;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  magnitude_to_decibels i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .magnitude_bits_i (magnitude_bits_i),
    .done_o           (done_o),
    .level_db_o       (level_db_o),
    .clipped_o        (clipped_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  db_level_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .magnitude_bits_i (magnitude_bits_i),
    .done_i           (done_o),
    .level_db_i       (level_db_o),
    .clipped_i        (clipped_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding)
  );

  // random magnitude, weighted toward the in-range band and the clip edges
  function automatic logic [31:0] random_magnitude();
    int unsigned pick;
    logic [31:0] val;
    logic [22:0] mant;
    pick = $urandom_range(99);
    val  = $urandom;
    if (pick < 45) begin
      val[31:23] = {1'b0, 8'($urandom_range(1, 252))};
    end else if (pick < 60) begin
      val[31:23] = 9'd0;
    end else if (pick < 70) begin
      // raw bit pattern
    end else if (pick < 78) begin
      val = 32'h006C_E3EE + 32'($urandom_range(64)) - 32'd32;
    end else if (pick < 84) begin
      val = 32'h7E96_7699 + 32'($urandom_range(64)) - 32'd32;
    end else if (pick < 92) begin
      // mantissa near sqrt(0.5), where the renormalization flips
      mant = 23'h35_04F3 + 23'($urandom_range(64)) - 23'd32;
      val  = {1'b0, 8'($urandom_range(1, 252)), mant};
    end else begin
      // infinities and nan with either sign
      val[30:23] = 8'hFF;
      if ($urandom_range(1) == 0) val[22:0] = 23'd0;
    end
    return val;
  endfunction

  // one start transaction, after a random gap at the current idle rate
  task automatic send_magnitude(input logic [31:0] bits);
    while ($urandom_range(99) < idle_pct) begin
      start_i          <= 1'b0;
      magnitude_bits_i <= $urandom;
      @(posedge clk_i);
    end
    start_i          <= 1'b1;
    magnitude_bits_i <= bits;
    do @(posedge clk_i); while (busy_o);
  endtask

  // hold off until every predicted result has come back
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mode register write, only while the block is idle
  task automatic write_amp_mode(input logic amp);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= amp;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // end the run when no transaction of any kind moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner magnitudes on the power scale
    write_amp_mode(1'b0);
    foreach (CornerMagnitudes[i]) send_magnitude(CornerMagnitudes[i]);
    drain_results();

    // random phases, alternating scale and sender gap rate
    for (int p = 0; p < PhaseCount; p++) begin
      write_amp_mode(PhaseAmp[p]);
      idle_pct = PhaseIdlePct[p];
      for (int n = 0; n < ItemsPerPhase; n++) send_magnitude(random_magnitude());
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/m2db_pkg.sv
src/magnitude_to_decibels.sv
src/m2db_checker.sv
tb/sv/db_level_checker.sv
tb/sv/tb_magnitude_to_decibels.sv
